// ===== rtl/srcc_pkg.sv =====
// ----------------------------------------------------------------------------
// srcc_pkg: shared types and constants for the small register CPU core
// Opcodes, field widths and the divider request/response structs.
// ----------------------------------------------------------------------------
`default_nettype none

package srcc_pkg;

	localparam int DefMemBytes = 256;
	localparam int DefNumRegs  = 8;
	localparam int XLEN        = 32;
	localparam int RIDX_W      = 3;
	localparam int IMM_W       = 21;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// opcodes
	localparam logic [7:0] OP_HLT  = 8'd0;
	localparam logic [7:0] OP_NOP  = 8'd1;
	localparam logic [7:0] OP_ADD  = 8'd2;
	localparam logic [7:0] OP_SUB  = 8'd3;
	localparam logic [7:0] OP_MUL  = 8'd4;
	localparam logic [7:0] OP_DIV  = 8'd5;
	localparam logic [7:0] OP_CMP  = 8'd6;
	localparam logic [7:0] OP_MOVR = 8'd7;
	localparam logic [7:0] OP_AND  = 8'd8;
	localparam logic [7:0] OP_OR   = 8'd9;
	localparam logic [7:0] OP_XOR  = 8'd10;
	localparam logic [7:0] OP_NOT  = 8'd11;
	localparam logic [7:0] OP_JE   = 8'd12;
	localparam logic [7:0] OP_JNE  = 8'd13;
	localparam logic [7:0] OP_JL   = 8'd14;
	localparam logic [7:0] OP_JLE  = 8'd15;
	localparam logic [7:0] OP_JG   = 8'd16;
	localparam logic [7:0] OP_JGE  = 8'd17;
	localparam logic [7:0] OP_JMP  = 8'd18;
	localparam logic [7:0] OP_LD   = 8'd19;
	localparam logic [7:0] OP_ST   = 8'd20;
	localparam logic [7:0] OP_MOVI = 8'd21;
	localparam logic [7:0] OP_ADDI = 8'd22;
	localparam logic [7:0] OP_SUBI = 8'd23;
	localparam logic [7:0] OP_MULI = 8'd24;
	localparam logic [7:0] OP_DIVI = 8'd25;
	localparam logic [7:0] OP_LSH  = 8'd26;
	localparam logic [7:0] OP_RSH  = 8'd27;

	// divider handshake
	typedef struct packed {
		logic            start;
		logic [XLEN-1:0] dividend;
		logic [XLEN-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [XLEN-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/small_register_cpu_core.sv =====
// small_register_cpu_core: multi-cycle 32-bit CPU, 8 registers, byte memory.
// Memory write request: byte written in the fetch state, then result handshake.
// Step: fetch four bytes at pc, read ra and rb, execute, mul/div/ld/st states,
// write back, result handshake (zero divisor: no divider wait). Halted step: result.
// One request at a time; the next is taken in the cycle after the result.
// Reset clears pc, flags, halt and register file (valid bits); memory undefined.
// ----------------------------------------------------------------------------
// small_register_cpu_core: top level
// Sequencer around a byte memory and a register file memory.
// ----------------------------------------------------------------------------
`default_nettype none

module small_register_cpu_core #(
	parameter int MEM_BYTES = srcc_pkg::DefMemBytes,
	parameter int NUM_REGS  = srcc_pkg::DefNumRegs
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [7:0] mem_address, [15:8] mem_byte
	input  wire         s_tuser,  // [0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	// [7:0] program_counter, [15:8] executed_opcode, [18:16] dest_index,
	// [50:19] dest_value, [55:51] zero
	output logic [55:0] m_tdata,
	output logic [5:0]  m_tuser   // halted, reg_written, eq, lt, gt, divide_by_zero
);
	import srcc_pkg::*;

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FETCH = 4'd1;
	localparam logic [3:0] ST_FWAIT = 4'd2;
	localparam logic [3:0] ST_RREAD = 4'd3;
	localparam logic [3:0] ST_EXEC  = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_LD    = 4'd7;
	localparam logic [3:0] ST_ST    = 4'd8;
	localparam logic [3:0] ST_WB    = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	// memories
	logic [7:0]      mem [MEM_BYTES];
	logic [7:0]      mem_rd_q;
	logic [XLEN-1:0] rf [NUM_REGS];
	logic [XLEN-1:0] rf_rd_q;
	logic [NUM_REGS-1:0] rf_vld_q;

	logic [3:0]      state_q;
	logic [2:0]      bcnt_q;
	logic [AW-1:0]   pc_q;
	logic [2:0]      flags_q;
	logic            halt_q;
	logic [XLEN-1:0] word_q;
	logic [XLEN-1:0] a_q, b_q, val_q, prod_q;
	logic            wrote_q, dz_q;
	logic [7:0]      opc_q;
	logic            rsel_q;
	logic [7:0]      in_addr_q, in_byte_q;

	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [7:0]      mem_wd;
	logic            rf_we;
	logic [RIDX_W-1:0] rf_raddr;

	div_req_t        dreq;
	div_rsp_t        drsp;

	wire [7:0]       opc = word_q[31:24];
	wire [2:0]       ra  = word_q[23:21];
	wire [2:0]       rb  = word_q[20:18];
	wire [XLEN-1:0]  imm = {11'd0, word_q[IMM_W-1:0]};
	wire [AW-1:0]    base = (opc == OP_LD || opc == OP_ST) ? AW'(word_q[IMM_W-1:0]) : pc_q;

	srcc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (state_q == ST_IDLE);

	// memory port control
	always_comb begin
		mem_we   = 1'b0;
		mem_wd   = in_byte_q;
		mem_addr = base + AW'(bcnt_q[1:0]);
		if (state_q == ST_FETCH && wrote_q) begin
			mem_we   = 1'b1;
			mem_addr = AW'(in_addr_q);
		end
		if (state_q == ST_ST) begin
			mem_we = 1'b1;
			unique case (bcnt_q[1:0])
				2'd0: mem_wd = a_q[31:24];
				2'd1: mem_wd = 8'((a_q & 32'h00ff0000) >> 16);
				2'd2: mem_wd = 8'((a_q & 32'h0000ff00) >> 8);
				default: mem_wd = 8'(a_q & 32'h000000ff);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		mem_rd_q <= mem[mem_addr];
	end

	// register file: single shared address, one write and one read per cycle
	assign rf_we    = (state_q == ST_WB) && wrote_q;
	assign rf_raddr = (state_q == ST_WB) ? ra : (rsel_q ? rb : ra);

	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_raddr] <= val_q;
		rf_rd_q <= rf_vld_q[rf_raddr] ? rf[rf_raddr] : '0;
	end

	always_comb begin
		dreq.start    = (state_q == ST_EXEC) && (opc == OP_DIV || opc == OP_DIVI);
		dreq.dividend = a_q;
		dreq.divisor  = (opc == OP_DIVI) ? imm : b_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pc_q     <= '0;
			flags_q  <= '0;
			halt_q   <= 1'b0;
			rf_vld_q <= '0;
			bcnt_q   <= '0;
			rsel_q   <= 1'b0;
			wrote_q  <= 1'b0;
			dz_q     <= 1'b0;
			opc_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						wrote_q <= 1'b0;
						dz_q    <= 1'b0;
						opc_q   <= OP_HLT;
						bcnt_q  <= '0;
						rsel_q  <= 1'b0;
						if (s_tuser == CMD_LOAD) begin
							wrote_q <= 1'b1;
							state_q <= ST_FETCH;
						end else if (halt_q) begin
							state_q <= ST_OUT;
						end else begin
							word_q  <= {8'hff, 24'd0};
							state_q <= ST_FWAIT;
						end
					end
				end
				ST_FETCH: begin
					// byte write request
					wrote_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_FWAIT: begin
					// read four bytes at pc; read data is registered
					if (bcnt_q != 3'd0)
						word_q <= {word_q[23:0], mem_rd_q};
					bcnt_q <= bcnt_q + 3'd1;
					if (bcnt_q == 3'd4) begin
						bcnt_q  <= '0;
						state_q <= ST_RREAD;
					end
				end
				ST_RREAD: begin
					rsel_q <= ~rsel_q;
					if (rsel_q) begin
						a_q <= rf_rd_q;
					end
					if (bcnt_q == 3'd2) begin
						b_q     <= rf_rd_q;
						bcnt_q  <= '0;
						rsel_q  <= 1'b0;
						state_q <= ST_EXEC;
					end else begin
						bcnt_q <= bcnt_q + 3'd1;
					end
				end
				ST_EXEC: begin
					opc_q   <= opc;
					wrote_q <= 1'b1;
					val_q   <= '0;
					pc_q    <= pc_q + AW'(4);
					state_q <= ST_WB;
					case (opc) inside
						OP_HLT: begin
							halt_q  <= 1'b1;
							pc_q    <= pc_q;
							wrote_q <= 1'b0;
						end
						OP_ADD:  val_q <= a_q + b_q;
						OP_SUB:  val_q <= a_q - b_q;
						OP_MUL, OP_MULI: begin
							prod_q  <= a_q * ((opc == OP_MUL) ? b_q : imm);
							state_q <= ST_MUL;
						end
						OP_DIV, OP_DIVI: state_q <= ST_DIV;
						OP_CMP: begin
							wrote_q <= 1'b0;
							flags_q <= {a_q > b_q, a_q < b_q, a_q == b_q};
						end
						OP_MOVR: val_q <= b_q;
						OP_AND:  val_q <= a_q & b_q;
						OP_OR:   val_q <= a_q | b_q;
						OP_XOR:  val_q <= a_q ^ b_q;
						OP_NOT:  val_q <= ~a_q;
						OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE, OP_JMP: begin
							wrote_q <= 1'b0;
							if ((opc == OP_JMP)
							    || (opc == OP_JE && flags_q[0])
							    || (opc == OP_JNE && !flags_q[0])
							    || (opc == OP_JL && flags_q[1])
							    || (opc == OP_JLE && (flags_q[0] || flags_q[1]))
							    || (opc == OP_JG && flags_q[2])
							    || (opc == OP_JGE && (flags_q[0] || flags_q[2])))
								pc_q <= AW'(word_q[IMM_W-1:0]);
						end
						OP_LD: begin
							bcnt_q  <= '0;
							state_q <= ST_LD;
						end
						OP_ST: begin
							wrote_q <= 1'b0;
							bcnt_q  <= '0;
							state_q <= ST_ST;
						end
						OP_MOVI: val_q <= imm;
						OP_ADDI: val_q <= a_q + imm;
						OP_SUBI: val_q <= a_q - imm;
						OP_LSH:  val_q <= (imm >= 32) ? '0 : a_q << imm[4:0];
						OP_RSH:  val_q <= (imm >= 32) ? '0 : a_q >> imm[4:0];
						default: wrote_q <= 1'b0;
					endcase
				end
				ST_MUL: begin
					val_q   <= prod_q;
					state_q <= ST_WB;
				end
				ST_DIV: begin
					if (dreq.divisor == '0) begin
						val_q   <= '1;
						dz_q    <= 1'b1;
						state_q <= ST_WB;
					end else if (drsp.done) begin
						val_q   <= drsp.quotient;
						state_q <= ST_WB;
					end
				end
				ST_LD: begin
					if (bcnt_q != 3'd0)
						val_q <= {val_q[23:0], mem_rd_q};
					bcnt_q <= bcnt_q + 3'd1;
					if (bcnt_q == 3'd4) begin
						bcnt_q  <= '0;
						state_q <= ST_WB;
					end
				end
				ST_ST: begin
					bcnt_q <= bcnt_q + 3'd1;
					if (bcnt_q == 3'd3) begin
						bcnt_q  <= '0;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wrote_q) rf_vld_q[ra] <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch request fields for a byte write
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			in_addr_q <= s_tdata[7:0];
			in_byte_q <= s_tdata[15:8];
		end
	end

	// result packing
	assign m_tdata = {5'd0, wrote_q ? val_q : 32'd0, wrote_q ? ra : 3'd0, opc_q, 8'(pc_q)};
	assign m_tuser = {dz_q, flags_q[2], flags_q[1], flags_q[0], wrote_q, halt_q};

endmodule

`default_nettype wire

// ===== rtl/srcc_divider.sv =====
// ----------------------------------------------------------------------------
// srcc_divider: unsigned 32-bit restoring divider
// One quotient bit per cycle while busy; done is raised with the last bit. Zero divisor is
// handled outside.
// ----------------------------------------------------------------------------
`default_nettype none

module srcc_divider (
	input  wire                 clk,
	input  wire                 arst_n,
	input  srcc_pkg::div_req_t  req,
	output srcc_pkg::div_rsp_t  rsp
);
	import srcc_pkg::*;

	logic [XLEN-1:0] rem_q;
	logic [XLEN-1:0] quo_q;
	logic [XLEN-1:0] dsr_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [XLEN:0]   trial;
	logic [XLEN:0]   shifted;

	// shift in next dividend bit, try subtract
	assign shifted = {rem_q, quo_q[XLEN-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(XLEN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[XLEN]) begin
				rem_q <= trial[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= shifted[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/srcc_checker.sv =====
// ----------------------------------------------------------------------------
// srcc_checker: port-level checks for the CPU core
// Handshake rules and request/result pairing.
// ----------------------------------------------------------------------------
`default_nettype none

module srcc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [55:0] m_tdata
);
	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no new request while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken with result pending");

	// a request acceptance is not followed by ready next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after request");

endmodule

bind small_register_cpu_core srcc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

`default_nettype wire
